>>> hw/rtl/cac_pkg.sv
// shared types and constants for the card access controller
package cac_pkg;

  localparam int TableEntries = 16;
  localparam int CntW = $clog2(TableEntries + 1);

  // item kinds
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_PRESENT = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_GRANTED = 3'd5;
  localparam logic [2:0] ST_DENIED = 3'd6;
  localparam logic [2:0] ST_TICK = 3'd7;

  // display actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_HOLDER = 2'd1;
  localparam logic [1:0] ACT_DENIED = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // message kinds
  localparam logic [1:0] MSG_NONE = 2'd0;
  localparam logic [1:0] MSG_HOLDER = 2'd1;
  localparam logic [1:0] MSG_DENIED = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_DOOR = 1'd0;
  localparam logic [0:0] REG_MESSAGE = 1'd1;

  // search token passed along the cell row
  typedef struct packed {
    logic        busy;
    logic        found;
    logic [15:0] holder;
    logic        free_seen;
  } cac_token_t;

  // command broadcast to every cell
  typedef struct packed {
    logic        start;
    logic        add;
    logic        remove;
    logic [63:0] lo;
    logic [15:0] hi;
    logic [3:0]  len;
    logic [15:0] tag;
  } cac_cmd_t;

endpackage

>>> hw/rtl/cac_cell.sv
// one whitelist slot: compares its id when the token arrives, passes it on
module cac_cell (
  input  logic              clk,
  input  logic              rst,
  input  cac_pkg::cac_cmd_t cmd,
  input  cac_pkg::cac_token_t tok_in,
  output cac_pkg::cac_token_t tok_out
);

  logic        valid;
  logic [63:0] id_lo;
  logic [15:0] id_hi;
  logic [3:0]  id_len;
  logic [15:0] holder;
  logic        hit;
  logic        take;

  assign hit = valid && id_len == cmd.len && id_lo == cmd.lo && id_hi == cmd.hi;
  // first free slot takes an add; duplicate check finishes at the row end
  assign take = tok_in.busy && cmd.add && !valid && !tok_in.free_seen;

  // slot storage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (tok_in.busy && cmd.remove && hit && !tok_in.found) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end
    if (take) begin
      id_lo <= cmd.lo;
      id_hi <= cmd.hi;
      id_len <= cmd.len;
      holder <= cmd.tag;
    end
  end

  // token register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.busy <= tok_in.busy;
      tok_out.found <= tok_in.found || (tok_in.busy && hit);
      tok_out.holder <= (tok_in.busy && hit && !tok_in.found) ? holder : tok_in.holder;
      tok_out.free_seen <= tok_in.free_seen || (tok_in.busy && !valid);
    end
  end

endmodule

>>> hw/rtl/cac_row.sv
// row of whitelist cells that a search token walks one cell per cycle
module cac_row (
  input  logic              clk,
  input  logic              rst,
  input  cac_pkg::cac_cmd_t cmd,
  output cac_pkg::cac_token_t result
);

  cac_pkg::cac_token_t chain [cac_pkg::TableEntries+1];
  cac_pkg::cac_cmd_t   ccmd;

  // add is only armed when the id is not already present (pre-checked)
  always_comb begin
    chain[0] = '0;
    chain[0].busy = cmd.start;
    ccmd = cmd;
  end

  for (genvar g = 0; g < cac_pkg::TableEntries; g++) begin : g_cell
    cac_cell u_cell (
      .clk(clk), .rst(rst), .cmd(ccmd),
      .tok_in(chain[g]), .tok_out(chain[g+1])
    );
  end

  assign result = chain[cac_pkg::TableEntries];

endmodule

>>> hw/rtl/card_access_controller_core.sv
// top level of the card access controller
// Usage: requests enter on s_axis (tdata packs kind, uid_low, uid_high,
// uid_length, holder_tag from bit 0 up). One result per request leaves on
// m_axis (tdata packs status, door_unlocked, display_action, shown_holder).
// Configuration writes (index 0 door seconds, 1 message seconds) use the
// cfg channel and are taken at any time; they should be made while idle.
// Table requests walk a token through the 16-cell row, one cell a cycle:
// a lookup pass, then for an add or remove that changes the table an
// update pass. A tick skips the row; its result is registered from idle.
// One request is in flight at a time. The result is held in an output
// register until m_axis_tready; a new request is taken only after the
// previous result leaves, so a stalled receiver stalls the input.
// Reset empties the table, closes the door and clears the display, and
// restores door 2 and message 3 seconds.
module card_access_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[1:0] uid_low[65:2] uid_high[81:66] uid_length[85:82] holder_tag[101:86]
  input  logic [103:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0] door_unlocked[3] display_action[5:4] shown_holder[21:6]
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0]  state;
  logic [7:0]  door_cfg, msg_cfg;
  logic [1:0]  kind;
  logic [63:0] lo;
  logic [15:0] hi;
  logic [3:0]  len;
  logic [15:0] tag;
  logic        door_held;
  logic [7:0]  door_el, msg_el;
  logic [1:0]  msg_kind;
  logic [15:0] cur_holder;
  logic        last_granted;
  logic [2:0]  o_status;
  logic [1:0]  o_action;
  logic [15:0] o_shown;
  logic        ovalid;

  cac_pkg::cac_cmd_t   cmd;
  cac_pkg::cac_token_t res;

  logic [3:0]  in_len_c;
  logic [63:0] lo_mask;
  logic [15:0] hi_mask;
  logic [7:0]  door_inc, msg_inc;

  // length clamp and byte masks of the incoming id
  always_comb begin
    in_len_c = (s_axis_tdata[85:82] > 4'd10) ? 4'd10 : s_axis_tdata[85:82];
    lo_mask = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < in_len_c) lo_mask[b*8 +: 8] = 8'hFF;
    end
    hi_mask = {(in_len_c > 4'd9) ? 8'hFF : 8'h00, (in_len_c > 4'd8) ? 8'hFF : 8'h00};
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata = {2'b0, o_shown, o_action, door_held, o_status};

  // cell row commands; the row result returns a fixed delay after start
  logic [cac_pkg::CntW:0] wait_cnt;
  always_comb begin
    cmd.lo = lo;
    cmd.hi = hi;
    cmd.len = len;
    cmd.tag = tag;
    cmd.start = 1'b0;
    cmd.add = 1'b0;
    cmd.remove = 1'b0;
    if (state == S_LOOK && wait_cnt == '0) cmd.start = 1'b1;
    // the update kind stays armed while the token walks the row
    if (state == S_UPD) begin
      if (wait_cnt == '0) cmd.start = 1'b1;
      cmd.add = (kind == cac_pkg::KIND_ADD);
      cmd.remove = (kind == cac_pkg::KIND_REMOVE);
    end
  end

  cac_row u_row (.clk(clk), .rst(rst), .cmd(cmd), .result(res));

  assign door_inc = (door_el == 8'hFF) ? door_el : door_el + 8'd1;
  assign msg_inc = (msg_el == 8'hFF) ? msg_el : msg_el + 8'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      door_cfg <= 8'd2;
      msg_cfg <= 8'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        cac_pkg::REG_DOOR: door_cfg <= cfg_data;
        cac_pkg::REG_MESSAGE: msg_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovalid <= 1'b0;
      wait_cnt <= '0;
      door_held <= 1'b0;
      door_el <= '0;
      msg_kind <= cac_pkg::MSG_NONE;
      msg_el <= '0;
      cur_holder <= '0;
      last_granted <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind <= s_axis_tdata[1:0];
            lo <= s_axis_tdata[65:2] & lo_mask;
            hi <= s_axis_tdata[81:66] & hi_mask;
            len <= in_len_c;
            tag <= s_axis_tdata[101:86];
            wait_cnt <= '0;
            o_action <= cac_pkg::ACT_NONE;
            o_shown <= '0;
            if (s_axis_tdata[1:0] == cac_pkg::KIND_TICK) begin
              o_status <= cac_pkg::ST_TICK;
              if (door_held) begin
                if (door_inc > door_cfg) begin
                  door_held <= 1'b0;
                  door_el <= '0;
                end else begin
                  door_el <= door_inc;
                end
              end
              if (msg_kind != cac_pkg::MSG_NONE) begin
                if (msg_inc > msg_cfg) begin
                  msg_kind <= cac_pkg::MSG_NONE;
                  msg_el <= '0;
                  o_action <= cac_pkg::ACT_CLEAR;
                end else begin
                  msg_el <= msg_inc;
                end
              end
              state <= S_OUT;
              ovalid <= 1'b1;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          wait_cnt <= wait_cnt + 1'b1;
          if (wait_cnt == (cac_pkg::CntW+1)'(cac_pkg::TableEntries)) begin
            wait_cnt <= '0;
            case (kind)
              cac_pkg::KIND_ADD: begin
                if (res.found) begin
                  o_status <= cac_pkg::ST_DUPLICATE;
                  state <= S_OUT;
                  ovalid <= 1'b1;
                end else if (res.free_seen) begin
                  o_status <= cac_pkg::ST_ADDED;
                  state <= S_UPD;
                end else begin
                  o_status <= cac_pkg::ST_FULL;
                  state <= S_OUT;
                  ovalid <= 1'b1;
                end
              end
              cac_pkg::KIND_REMOVE: begin
                if (res.found) begin
                  o_status <= cac_pkg::ST_REMOVED;
                  state <= S_UPD;
                end else begin
                  o_status <= cac_pkg::ST_NOT_FOUND;
                  state <= S_OUT;
                  ovalid <= 1'b1;
                end
              end
              default: begin
                if (res.found) begin
                  o_status <= cac_pkg::ST_GRANTED;
                  door_held <= 1'b1;
                  door_el <= '0;
                  if (!last_granted || msg_kind != cac_pkg::MSG_HOLDER ||
                      cur_holder != res.holder) begin
                    msg_kind <= cac_pkg::MSG_HOLDER;
                    msg_el <= '0;
                    cur_holder <= res.holder;
                    o_action <= cac_pkg::ACT_HOLDER;
                    o_shown <= res.holder;
                  end
                  last_granted <= 1'b1;
                end else begin
                  o_status <= cac_pkg::ST_DENIED;
                  door_held <= 1'b0;
                  if (msg_kind != cac_pkg::MSG_DENIED) begin
                    msg_kind <= cac_pkg::MSG_DENIED;
                    msg_el <= '0;
                    o_action <= cac_pkg::ACT_DENIED;
                  end
                  last_granted <= 1'b0;
                end
                state <= S_OUT;
                ovalid <= 1'b1;
              end
            endcase
          end
        end
        S_UPD: begin
          wait_cnt <= wait_cnt + 1'b1;
          if (wait_cnt == (cac_pkg::CntW+1)'(cac_pkg::TableEntries)) begin
            wait_cnt <= '0;
            state <= S_OUT;
            ovalid <= 1'b1;
          end
        end
        default: begin
          if (m_axis_tready) begin
            ovalid <= 1'b0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result is offered only in the output state
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_OUT) else $error("result outside output state");
  // no request accepted while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("request taken with result pending");
  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
`endif

endmodule

>>> tb/sv/card_access_controller_core_tb.sv
// testbench for the card access controller core: random and directed requests, scoreboard check
module card_access_controller_core_tb;

  // one decoded request
  typedef struct {
    logic [1:0]  kind;
    logic [63:0] lo;
    logic [15:0] hi;
    logic [3:0]  len;
    logic [15:0] tag;
  } req_t;

  // one decoded response
  typedef struct {
    logic [2:0]  status;
    logic        door;
    logic [1:0]  action;
    logic [15:0] shown;
  } rsp_t;

  // behavioral copy of the controller with a queue of expected responses
  class access_scoreboard;
    logic        valid_q [cac_pkg::TableEntries];
    logic [63:0] lo_q [cac_pkg::TableEntries];
    logic [15:0] hi_q [cac_pkg::TableEntries];
    logic [3:0]  len_q [cac_pkg::TableEntries];
    logic [15:0] holder_q [cac_pkg::TableEntries];
    logic        door_held;
    logic [7:0]  door_ticks;
    logic [1:0]  msg_kind;
    logic [7:0]  msg_ticks;
    logic [15:0] cur_holder;
    logic        granted_last;
    logic [7:0]  door_secs;
    logic [7:0]  msg_secs;
    rsp_t        pending[$];
    int          errors;

    function void clear();
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      door_held = 0; door_ticks = 0; msg_kind = cac_pkg::MSG_NONE; msg_ticks = 0;
      cur_holder = 0; granted_last = 0; door_secs = 8'd2; msg_secs = 8'd3;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] val);
      if (idx == cac_pkg::REG_DOOR) door_secs = val;
      else msg_secs = val;
    endfunction

    function int lookup(logic [63:0] lo, logic [15:0] hi, logic [3:0] len);
      for (int i = 0; i < cac_pkg::TableEntries; i++)
        if (valid_q[i] && len_q[i] == len && lo_q[i] == lo && hi_q[i] == hi) return i;
      return -1;
    endfunction

    // work out the response for an accepted request
    function void note_request(req_t r);
      rsp_t        e;
      logic [3:0]  len;
      logic [63:0] lo;
      logic [15:0] hi;
      int          idx;
      e = '{cac_pkg::ST_TICK, 1'b0, cac_pkg::ACT_NONE, 16'd0};
      len = (r.len > 4'd10) ? 4'd10 : r.len;
      lo = (len >= 8) ? r.lo : (r.lo & ((64'd1 << (8 * len)) - 64'd1));
      hi = (len <= 8) ? 16'd0 : (len == 9) ? (r.hi & 16'h00ff) : r.hi;
      idx = lookup(lo, hi, len);
      case (r.kind)
        cac_pkg::KIND_ADD: begin
          if (idx >= 0) e.status = cac_pkg::ST_DUPLICATE;
          else begin
            e.status = cac_pkg::ST_FULL;
            for (int i = 0; i < cac_pkg::TableEntries; i++)
              if (!valid_q[i]) begin
                valid_q[i] = 1; lo_q[i] = lo; hi_q[i] = hi; len_q[i] = len;
                holder_q[i] = r.tag; e.status = cac_pkg::ST_ADDED;
                break;
              end
          end
        end
        cac_pkg::KIND_REMOVE: begin
          if (idx >= 0) begin
            valid_q[idx] = 0; e.status = cac_pkg::ST_REMOVED;
          end else e.status = cac_pkg::ST_NOT_FOUND;
        end
        cac_pkg::KIND_PRESENT: begin
          if (idx >= 0) begin
            e.status = cac_pkg::ST_GRANTED; door_held = 1; door_ticks = 0;
            if (!granted_last || msg_kind != cac_pkg::MSG_HOLDER ||
                cur_holder != holder_q[idx]) begin
              msg_kind = cac_pkg::MSG_HOLDER; msg_ticks = 0; cur_holder = holder_q[idx];
              e.action = cac_pkg::ACT_HOLDER; e.shown = holder_q[idx];
            end
            granted_last = 1;
          end else begin
            e.status = cac_pkg::ST_DENIED; door_held = 0;
            if (msg_kind != cac_pkg::MSG_DENIED) begin
              msg_kind = cac_pkg::MSG_DENIED; msg_ticks = 0; e.action = cac_pkg::ACT_DENIED;
            end
            granted_last = 0;
          end
        end
        default: begin
          if (door_held) begin
            if (door_ticks != 8'hff) door_ticks++;
            if (door_ticks > door_secs) begin
              door_held = 0; door_ticks = 0;
            end
          end
          if (msg_kind != cac_pkg::MSG_NONE) begin
            if (msg_ticks != 8'hff) msg_ticks++;
            if (msg_ticks > msg_secs) begin
              msg_kind = cac_pkg::MSG_NONE; msg_ticks = 0; e.action = cac_pkg::ACT_CLEAR;
            end
          end
        end
      endcase
      e.door = door_held;
      pending.push_back(e);
    endfunction

    function void check_response(logic [23:0] d);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected response %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[2:0] != e.status) begin
        $error("status exp %0d got %0d", e.status, d[2:0]); errors++;
      end
      if (d[3] != e.door) begin
        $error("door_unlocked exp %0d got %0d", e.door, d[3]); errors++;
      end
      if (d[5:4] != e.action) begin
        $error("display_action exp %0d got %0d", e.action, d[5:4]); errors++;
      end
      if (d[21:6] != e.shown) begin
        $error("shown_holder exp %h got %h", e.shown, d[21:6]); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [23:0]  m_axis_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic         cfg_index = 0;
  logic [7:0]   cfg_data = 0;

  access_scoreboard sb = new();
  int  send_idle_pct = 24;
  int  recv_idle_pct = 79;
  logic hold_req = 0;
  logic hold_done = 0;
  int  hold_cnt = 0;
  int  cycles = 0;
  logic [63:0] ids_lo [8];
  logic [15:0] ids_hi [8];
  logic [3:0]  ids_len [8];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  card_access_controller_core u_top (.*);

  // response side with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata);
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 0;
      end else if (hold_req && !hold_done) begin
        hold_cnt <= 300;
        hold_done <= 1;
        m_axis_tready <= 0;
      end else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("card_access_controller_core_tb: done, errors");
      $finish;
    end
  end

  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tdata <= {2'b0, r.tag, r.len, r.hi, r.lo, r.kind};
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(r);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic req_t pick_request();
    req_t r;
    int   k;
    r.kind = 2'($urandom_range(3));
    r.tag = 16'($urandom_range(3));
    if ($urandom_range(9) < 7) begin
      k = $urandom_range(7);
      r.lo = ids_lo[k]; r.hi = ids_hi[k]; r.len = ids_len[k];
      if ($urandom_range(3) == 0) r.tag = 16'($urandom);
      if ($urandom_range(5) == 0) begin
        r.lo = r.lo | ({$urandom, $urandom} & ~((64'd1 << (8 * r.len)) - 64'd1));
        if (r.len < 10) r.hi = 16'($urandom);
      end
    end else begin
      r.lo = {$urandom, $urandom}; r.hi = 16'($urandom); r.len = 4'($urandom_range(15));
      r.tag = 16'($urandom);
    end
    if (r.kind == cac_pkg::KIND_TICK && $urandom_range(1)) r.kind = cac_pkg::KIND_PRESENT;
    return r;
  endfunction

  initial begin
    req_t r;
    sb.clear();
    foreach (ids_lo[i]) begin
      ids_lo[i] = {$urandom, $urandom}; ids_hi[i] = 16'($urandom);
      ids_len[i] = (i == 0) ? 4'd0 : (i == 1) ? 4'd10 : 4'($urandom_range(1, 10));
    end
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, duplicate, full table, lengths, timers
    send_request('{cac_pkg::KIND_PRESENT, 64'd0, 16'd0, 4'd0, 16'd0});
    send_request('{cac_pkg::KIND_ADD, 64'd0, 16'd0, 4'd0, 16'hffff});
    send_request('{cac_pkg::KIND_ADD, 64'd0, 16'd0, 4'd0, 16'd1});
    send_request('{cac_pkg::KIND_PRESENT, 64'hffff_ffff_ffff_ffff, 16'hffff, 4'd0, 16'd0});
    send_request('{cac_pkg::KIND_PRESENT, 64'hffff_ffff_ffff_ffff, 16'hffff, 4'd0, 16'd0});
    send_request('{cac_pkg::KIND_ADD, 64'hffff_ffff_ffff_ffff, 16'hffff, 4'd15, 16'd7});
    send_request('{cac_pkg::KIND_PRESENT, 64'hffff_ffff_ffff_ffff, 16'hffff, 4'd10, 16'd0});
    send_request('{cac_pkg::KIND_ADD, 64'h00ff, 16'd0, 4'd1, 16'd9});
    send_request('{cac_pkg::KIND_PRESENT, 64'h00ff, 16'd0, 4'd2, 16'd0});
    for (int i = 0; i < 4; i++)
      send_request('{cac_pkg::KIND_TICK, 64'd0, 16'd0, 4'd0, 16'd0});
    for (int i = 0; i < 15; i++)
      send_request('{cac_pkg::KIND_ADD, 64'(i + 5), 16'd0, 4'd9, 16'(i)});
    send_request('{cac_pkg::KIND_REMOVE, 64'd5, 16'd0, 4'd9, 16'd0});
    send_request('{cac_pkg::KIND_REMOVE, 64'd5, 16'd0, 4'd9, 16'd0});
    send_request('{cac_pkg::KIND_ADD, 64'd99, 16'hffff, 4'd10, 16'd3});
    drain();
    for (int i = 0; i < 16; i++)
      send_request('{cac_pkg::KIND_REMOVE, 64'(i + 5), 16'd0, 4'd9, 16'd0});
    send_request('{cac_pkg::KIND_REMOVE, 64'hffff_ffff_ffff_ffff, 16'hffff, 4'd10, 16'd0});
    send_request('{cac_pkg::KIND_REMOVE, 64'd0, 16'd0, 4'd0, 16'd0});
    send_request('{cac_pkg::KIND_REMOVE, 64'h00ff, 16'd0, 4'd1, 16'd0});
    send_request('{cac_pkg::KIND_REMOVE, 64'd99, 16'hffff, 4'd10, 16'd0});
    drain();

    // random phases across register settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(cac_pkg::REG_DOOR, ph == 0 ? 8'd0 : ph == 1 ? 8'd255 : 8'($urandom_range(5)));
      write_reg(cac_pkg::REG_MESSAGE,
                ph == 0 ? 8'd255 : ph == 1 ? 8'd0 : 8'($urandom_range(5)));
      cfg_valid <= 0;
      send_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 79 : 0;
      recv_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 24 : 0;
      if (ph == 4) hold_req = 1;
      for (int n = 0; n < 240; n++) begin
        r = pick_request();
        send_request(r);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("card_access_controller_core_tb: done, clean");
    end else begin
      $display("card_access_controller_core_tb: done, errors");
    end
    $finish;
  end
endmodule
